[design/stla_pkg.sv]
// Shared types and constants for the session table lookup/alloc block.
`timescale 1ns / 1ps

package stla_pkg;

  // Default table size and fixed field widths
  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned KEY_W     = ADDR_W + PORT_W;
  localparam int unsigned HINT_W    = 7;
  localparam int unsigned MAXS_W    = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned ULEN_W    = 7;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 3'd0,
    MODE_CREATE = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_REWIND = 3'd3,
    MODE_NEXT   = 3'd4,
    MODE_END    = 3'd5
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 3'd0,
    ST_CREATED = 3'd1,
    ST_NONE    = 3'd2,
    ST_FULL    = 3'd3,
    ST_REMOVED = 3'd4
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HINT  = 9'b000000010,
    S_HCHK  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_ABOVE = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_WREAD = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage

[design/stla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/session_table_lookup_alloc.sv]
// Session table: keyed lookup, lookup-or-create, remove and cursor walk.
// Steps from accept to result: lookup/create run the hint check, then one slot per cycle
//   through the key RAM, then a create's write; remove scans to the hit,
//   then scans valid bits above it; next walks the cursor; others finish directly.
// Throughput: one item at a time; the next is taken in the cycle after its result is loaded.
// Reset clears the valid bits, used length, cursor and limit; the key RAM is not cleared.
`timescale 1ns / 1ps

module session_table_lookup_alloc #(
  parameter int unsigned SLOTS = stla_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stla_pkg::MAXS_W-1:0]   max_sessions_i,
  // request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [stla_pkg::MODE_W-1:0]   mode_i,
  input  logic [stla_pkg::ADDR_W-1:0]   peer_address_i,
  input  logic [stla_pkg::PORT_W-1:0]   peer_port_i,
  input  logic signed [stla_pkg::HINT_W-1:0] slot_hint_i,
  // result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stla_pkg::STATUS_W-1:0] status_o,
  output logic [stla_pkg::SLOT_W-1:0]   slot_index_o,
  output logic [stla_pkg::ADDR_W-1:0]   entry_address_o,
  output logic [stla_pkg::PORT_W-1:0]   entry_port_o,
  output logic [stla_pkg::ULEN_W-1:0]   used_length_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned LEN_W = $clog2(SLOTS + 1);
  localparam int unsigned CUR_W = (LEN_W > 7) ? LEN_W : 7;
  localparam int unsigned KEY_W = stla_pkg::KEY_W;
  localparam int unsigned PORT_W = stla_pkg::PORT_W;

  // Control state
  stla_pkg::state_e               state_q, state_d;
  logic [SLOTS-1:0]               valid_q, valid_d;
  logic [LEN_W-1:0]               len_q, len_d;
  logic [CUR_W-1:0]               cur_q, cur_d;
  logic [stla_pkg::MAXS_W-1:0]    max_q;
  logic                           pend_q, pend_d;
  logic                           hole_found_q, hole_found_d;
  logic                           out_valid_q, out_valid_d;

  // Item payload and working registers
  stla_pkg::mode_e                mode_q, mode_d;
  logic [KEY_W-1:0]               key_q, key_d;
  logic [IDX_W-1:0]               hint_q, hint_d;
  logic [LEN_W-1:0]               idx_q, idx_d;
  logic [IDX_W-1:0]               pidx_q, pidx_d;
  logic [IDX_W-1:0]               hole_q, hole_d;
  logic [IDX_W-1:0]               wslot_q, wslot_d;
  stla_pkg::status_e              res_status_q, res_status_d;
  logic [IDX_W-1:0]               res_slot_q, res_slot_d;
  logic [KEY_W-1:0]               res_key_q, res_key_d;
  stla_pkg::status_e              out_status_q;
  logic [IDX_W-1:0]               out_slot_q;
  logic [KEY_W-1:0]               out_key_q;
  logic [LEN_W-1:0]               out_len_q;

  // Key RAM ports
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_raddr;
  logic [KEY_W-1:0]               ram_rdata;

  // Combinational helpers
  logic                           in_fire;
  logic                           out_load;
  logic                           hit;
  logic [IDX_W-1:0]               hit_slot;
  logic [CUR_W-1:0]               hint_ext;
  logic [CUR_W-1:0]               len_ext;
  logic                           table_full;
  logic [CUR_W-1:0]               slot_ext;
  logic [CUR_W-1:0]               ulen_ext;

  stla_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (key_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == stla_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign ram_we      = (state_q == stla_pkg::S_WRITE);
  assign out_load    = (state_q == stla_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  assign hint_ext   = CUR_W'(slot_hint_i[stla_pkg::HINT_W-2:0]);
  assign len_ext    = CUR_W'(len_q);
  assign table_full = ((max_q != '0) && (len_ext >= CUR_W'(max_q)))
                      || (len_q >= LEN_W'(SLOTS));

  // Sequencer
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    len_d        = len_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    hole_found_d = hole_found_q;
    mode_d       = mode_q;
    key_d        = key_q;
    hint_d       = hint_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    hole_d       = hole_q;
    wslot_d      = wslot_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_key_d    = res_key_q;
    ram_raddr    = idx_q[IDX_W-1:0];
    hit          = 1'b0;
    hit_slot     = pidx_q;

    unique case (state_q)
      stla_pkg::S_IDLE: begin
        if (in_fire) begin
          mode_d       = stla_pkg::mode_e'(mode_i);
          key_d        = {peer_address_i, peer_port_i};
          hint_d       = hint_ext[IDX_W-1:0];
          idx_d        = '0;
          pend_d       = 1'b0;
          hole_found_d = 1'b0;
          res_status_d = stla_pkg::ST_NONE;
          res_slot_d   = '0;
          res_key_d    = '0;
          unique case (stla_pkg::mode_e'(mode_i))
            stla_pkg::MODE_LOOKUP, stla_pkg::MODE_CREATE, stla_pkg::MODE_REMOVE: begin
              if (!slot_hint_i[stla_pkg::HINT_W-1] && (hint_ext < len_ext)) begin
                state_d = stla_pkg::S_HINT;
              end else begin
                state_d = stla_pkg::S_SCAN;
              end
            end
            stla_pkg::MODE_REWIND: begin
              cur_d   = '0;
              state_d = stla_pkg::S_DONE;
            end
            stla_pkg::MODE_END: begin
              cur_d   = CUR_W'(max_q);
              state_d = stla_pkg::S_DONE;
            end
            stla_pkg::MODE_NEXT: begin
              state_d = stla_pkg::S_WALK;
            end
            default: begin
              state_d = stla_pkg::S_DONE;
            end
          endcase
        end
      end

      // Read the hinted slot
      stla_pkg::S_HINT: begin
        ram_raddr = hint_q;
        state_d   = stla_pkg::S_HCHK;
      end

      // Compare the hinted slot, else fall back to the scan
      stla_pkg::S_HCHK: begin
        hit_slot = hint_q;
        hit      = valid_q[hint_q] && (ram_rdata == key_q);
        if (!hit) begin
          state_d = stla_pkg::S_SCAN;
        end
      end

      // Pipelined scan: issue one read, compare the previous one
      stla_pkg::S_SCAN: begin
        pend_d = 1'b0;
        if (pend_q && valid_q[pidx_q] && (ram_rdata == key_q)) begin
          hit = 1'b1;
        end else begin
          if (pend_q && !valid_q[pidx_q] && !hole_found_q) begin
            hole_found_d = 1'b1;
            hole_d       = pidx_q;
          end
          if (idx_q < len_q) begin
            ram_raddr = idx_q[IDX_W-1:0];
            pend_d    = 1'b1;
            pidx_d    = idx_q[IDX_W-1:0];
            idx_d     = idx_q + LEN_W'(1);
          end else if (!pend_q) begin
            // Miss: a create reuses a hole, appends, or reports full
            state_d = stla_pkg::S_DONE;
            if (mode_q == stla_pkg::MODE_CREATE) begin
              if (hole_found_q) begin
                wslot_d = hole_q;
                state_d = stla_pkg::S_WRITE;
              end else if (table_full) begin
                res_status_d = stla_pkg::ST_FULL;
              end else begin
                wslot_d = len_q[IDX_W-1:0];
                len_d   = len_q + LEN_W'(1);
                state_d = stla_pkg::S_WRITE;
              end
            end
          end
        end
      end

      // Store the new key and mark the slot used
      stla_pkg::S_WRITE: begin
        valid_d[wslot_q] = 1'b1;
        res_status_d     = stla_pkg::ST_CREATED;
        res_slot_d       = wslot_q;
        state_d          = stla_pkg::S_DONE;
      end

      // Look for a used slot above the freed one; cut the length if none
      stla_pkg::S_ABOVE: begin
        if (idx_q >= len_q) begin
          len_d   = LEN_W'(res_slot_q);
          state_d = stla_pkg::S_DONE;
        end else if (valid_q[idx_q[IDX_W-1:0]]) begin
          state_d = stla_pkg::S_DONE;
        end else begin
          idx_d = idx_q + LEN_W'(1);
        end
      end

      // Advance the cursor past free slots
      stla_pkg::S_WALK: begin
        if (cur_q >= len_ext) begin
          cur_d   = '0;
          state_d = stla_pkg::S_DONE;
        end else if (!valid_q[cur_q[IDX_W-1:0]]) begin
          cur_d = cur_q + CUR_W'(1);
        end else begin
          ram_raddr = cur_q[IDX_W-1:0];
          state_d   = stla_pkg::S_WREAD;
        end
      end

      // Return the stored key at the cursor
      stla_pkg::S_WREAD: begin
        res_status_d = stla_pkg::ST_FOUND;
        res_slot_d   = cur_q[IDX_W-1:0];
        res_key_d    = ram_rdata;
        cur_d        = cur_q + CUR_W'(1);
        state_d      = stla_pkg::S_DONE;
      end

      // Hand the result to the output register
      stla_pkg::S_DONE: begin
        if (out_load) begin
          state_d = stla_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = stla_pkg::S_IDLE;
      end
    endcase

    // Key found by the hint check or the scan
    if (hit) begin
      res_slot_d = hit_slot;
      if (mode_q == stla_pkg::MODE_REMOVE) begin
        valid_d[hit_slot] = 1'b0;
        res_status_d      = stla_pkg::ST_REMOVED;
        idx_d             = LEN_W'(hit_slot) + LEN_W'(1);
        state_d           = stla_pkg::S_ABOVE;
      end else begin
        res_status_d = stla_pkg::ST_FOUND;
        state_d      = stla_pkg::S_DONE;
      end
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= stla_pkg::S_IDLE;
      valid_q      <= '0;
      len_q        <= '0;
      cur_q        <= '0;
      max_q        <= '0;
      pend_q       <= 1'b0;
      hole_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      len_q        <= len_d;
      cur_q        <= cur_d;
      pend_q       <= pend_d;
      hole_found_q <= hole_found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= max_sessions_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    hint_q       <= hint_d;
    idx_q        <= idx_d;
    pidx_q       <= pidx_d;
    hole_q       <= hole_d;
    wslot_q      <= wslot_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_key_q    <= res_key_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_key_q    <= res_key_q;
      out_len_q    <= len_q;
    end
  end

  // Drive the result ports
  assign slot_ext        = CUR_W'(out_slot_q);
  assign ulen_ext        = CUR_W'(out_len_q);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_index_o    = slot_ext[stla_pkg::SLOT_W-1:0];
  assign entry_address_o = out_key_q[KEY_W-1:PORT_W];
  assign entry_port_o    = out_key_q[PORT_W-1:0];
  assign used_length_o   = ulen_ext[stla_pkg::ULEN_W-1:0];

  // Used length never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(SLOTS))
    else $error("used length beyond table size");

  // A created slot is marked used right after the write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stla_pkg::S_WRITE) |=> valid_q[$past(wslot_q)])
    else $error("created slot not marked used");

  // A found or created slot lies below the reported used length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_status_q == stla_pkg::ST_FOUND)
                     || (out_status_q == stla_pkg::ST_CREATED)))
    |-> (LEN_W'(out_slot_q) < out_len_q))
    else $error("result slot outside used length");

endmodule

[dv/session_table_lookup_alloc_tb.sv]
// Self-checking testbench for the session table lookup/alloc block.
`timescale 1ns / 1ps

module session_table_lookup_alloc_tb;
  import stla_pkg::*;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int LONG_HOLD = 400;
  localparam int TAIL      = 2 * SLOTS + 10;

  // Modes outside the defined set
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  // Mid-phase events
  localparam int PH_PLAIN       = 0;
  localparam int PH_LONG_HOLD   = 1;
  localparam int PH_DRAIN_PAUSE = 2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [ULEN_W-1:0]   ulen;
  } sess_result_t;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [ADDR_W-1:0]        addr;
    logic [PORT_W-1:0]        port;
    logic signed [HINT_W-1:0] hint;
    bit                       typed;
    sess_result_t             want;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [MAXS_W-1:0]          max_sessions_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [MODE_W-1:0]          mode_i;
  logic [ADDR_W-1:0]          peer_address_i;
  logic [PORT_W-1:0]          peer_port_i;
  logic signed [HINT_W-1:0]   slot_hint_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [STATUS_W-1:0]        status_o;
  logic [SLOT_W-1:0]          slot_index_o;
  logic [ADDR_W-1:0]          entry_address_o;
  logic [PORT_W-1:0]          entry_port_o;
  logic [ULEN_W-1:0]          used_length_o;

  // Predicted table contents
  bit                sess_used [SLOTS];
  logic [ADDR_W-1:0] sess_addr [SLOTS];
  logic [PORT_W-1:0] sess_port [SLOTS];
  int                sess_len;
  int                walk_pos;
  int                sess_limit;

  sess_result_t pending_results [$];
  stim_row_t    dir_rows [$];
  int           bad_results;

  // Typed expectation for the item currently offered
  bit           row_typed;
  sess_result_t row_want;

  // Long receiver hold requests
  int stall_reqs;
  int stall_seen;

  // Per-phase key pool
  logic [ADDR_W-1:0] pool_a [96];
  logic [PORT_W-1:0] pool_p [96];

  session_table_lookup_alloc #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .max_sessions_i (max_sessions_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .peer_address_i (peer_address_i),
    .peer_port_i    (peer_port_i),
    .slot_hint_i    (slot_hint_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .entry_address_o(entry_address_o),
    .entry_port_o   (entry_port_o),
    .used_length_o  (used_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit key_at(int s, logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
    return sess_used[s] && sess_addr[s] == a && sess_port[s] == p;
  endfunction

  // Try the hinted slot, then scan from slot 0; -1 on a miss
  function automatic int key_find(logic signed [HINT_W-1:0] h, logic [ADDR_W-1:0] a,
                                  logic [PORT_W-1:0] p);
    int hv;
    int i;
    int found;
    hv = int'(h);
    found = -1;
    if (hv >= 0 && hv < sess_len && key_at(hv, a, p)) found = hv;
    i = 0;
    while (found < 0 && i < sess_len && i < SLOTS) begin
      if (key_at(i, a, p)) found = i;
      i++;
    end
    return found;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic sess_result_t session_update(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                                  logic [PORT_W-1:0] p,
                                                  logic signed [HINT_W-1:0] h);
    sess_result_t r;
    int hit;
    int hole;
    int i;
    bit above;
    r = '0;
    r.status = ST_NONE;
    if (m == MODE_LOOKUP || m == MODE_CREATE) begin
      hit = key_find(h, a, p);
      if (hit >= 0) begin
        r.status = ST_FOUND;
        r.slot = SLOT_W'(hit);
      end else if (m == MODE_CREATE) begin
        // reuse the lowest hole, else append within the limits
        hole = -1;
        i = 0;
        while (hole < 0 && i < sess_len && i < SLOTS) begin
          if (!sess_used[i]) hole = i;
          i++;
        end
        if (hole < 0) begin
          if ((sess_limit != 0 && sess_len >= sess_limit) || sess_len >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            hole = sess_len;
            sess_len++;
          end
        end
        if (hole >= 0) begin
          sess_used[hole] = 1'b1;
          sess_addr[hole] = a;
          sess_port[hole] = p;
          r.status = ST_CREATED;
          r.slot = SLOT_W'(hole);
        end
      end
    end else if (m == MODE_REMOVE) begin
      hit = key_find(h, a, p);
      if (hit >= 0) begin
        // free the slot, cut the length back when nothing used lies above
        sess_used[hit] = 1'b0;
        above = 1'b0;
        for (i = hit; i < sess_len && i < SLOTS; i++)
          if (sess_used[i]) above = 1'b1;
        if (!above) sess_len = hit;
        r.status = ST_REMOVED;
        r.slot = SLOT_W'(hit);
      end
    end else if (m == MODE_REWIND) begin
      walk_pos = 0;
    end else if (m == MODE_END) begin
      walk_pos = sess_limit;
    end else if (m == MODE_NEXT) begin
      while (walk_pos < sess_len && walk_pos < SLOTS && !sess_used[walk_pos]) walk_pos++;
      if (walk_pos >= sess_len || walk_pos >= SLOTS) begin
        walk_pos = 0;
      end else begin
        r.status = ST_FOUND;
        r.slot = SLOT_W'(walk_pos);
        r.addr = sess_addr[walk_pos];
        r.port = sess_port[walk_pos];
        walk_pos++;
      end
    end
    r.ulen = ULEN_W'(sess_len);
    return r;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                  logic [PORT_W-1:0] p, int h, bit typed,
                                  logic [STATUS_W-1:0] st, int slot,
                                  logic [ADDR_W-1:0] ea, logic [PORT_W-1:0] ep, int len);
    stim_row_t row;
    row.mode = m;
    row.addr = a;
    row.port = p;
    row.hint = HINT_W'(h);
    row.typed = typed;
    row.want.status = st;
    row.want.slot = SLOT_W'(slot);
    row.want.addr = ea;
    row.want.port = ep;
    row.want.ulen = ULEN_W'(len);
    dir_rows.push_back(row);
  endfunction

  // Check results, predict accepted items, track register writes
  always @(posedge clk_i) begin : monitor
    sess_result_t got;
    sess_result_t want;
    sess_result_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.status = status_o;
        got.slot = slot_index_o;
        got.addr = entry_address_o;
        got.port = entry_port_o;
        got.ulen = used_length_o;
        if (pending_results.size() == 0) begin
          if (bad_results < 10)
            $display("unexpected result: status %0d slot %0d addr %h port %h len %0d",
                     got.status, got.slot, got.addr, got.port, got.ulen);
          bad_results++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.addr !== want.addr || got.port !== want.port || got.ulen !== want.ulen) begin
            if (bad_results < 10) begin
              $display("mismatch: exp status %0d slot %0d addr %h port %h len %0d",
                       want.status, want.slot, want.addr, want.port, want.ulen);
              $display("          got status %0d slot %0d addr %h port %h len %0d",
                       got.status, got.slot, got.addr, got.port, got.ulen);
            end
            bad_results++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = session_update(mode_i, peer_address_i, peer_port_i, slot_hint_i);
        pending_results.push_back(row_typed ? row_want : pred);
      end
      if (cfg_valid_i && cfg_ready_o) sess_limit = int'(max_sessions_i);
    end
  end

  // Receiver: changing stall pattern, plus long holds on request
  initial begin : receiver
    int pat_sel;
    int pat_left;
    int hold_left;
    out_ready_i = 1'b0;
    pat_sel = 0;
    pat_left = 0;
    hold_left = 0;
    stall_seen = 0;
    forever begin
      @(negedge clk_i);
      if (stall_reqs != stall_seen) begin
        stall_seen = stall_reqs;
        hold_left = LONG_HOLD;
      end
      if (pat_left == 0) begin
        pat_sel = $urandom_range(3);
        pat_left = $urandom_range(256, 64);
      end
      pat_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        case (pat_sel)
          0: out_ready_i = 1'b1;
          1: out_ready_i = ($urandom_range(3) != 0);
          2: out_ready_i = ($urandom_range(3) == 0);
          default: out_ready_i = pat_left[3];
        endcase
      end
    end
  end

  // Offer one item at a falling edge and hold it until accepted
  task automatic send_item(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                           logic signed [HINT_W-1:0] h);
    in_valid_i = 1'b1;
    mode_i = m;
    peer_address_i = a;
    peer_port_i = p;
    slot_hint_i = h;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(int v);
    cfg_valid_i = 1'b1;
    max_sessions_i = MAXS_W'(v);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One random phase under one limit setting
  task automatic run_phase(int limit, int count, int bias, int pool_n, bit gaps, int event_code);
    int n;
    int r;
    int k;
    int s;
    int burst_left;
    logic [MODE_W-1:0]        m;
    logic [ADDR_W-1:0]        a;
    logic [PORT_W-1:0]        p;
    logic signed [HINT_W-1:0] h;
    drain_results();
    write_limit(limit);
    // build keys, some sharing one half of the previous key
    for (k = 0; k < pool_n; k++) begin
      r = $urandom_range(9);
      if (k > 0 && r < 2) begin
        pool_a[k] = pool_a[k-1];
        pool_p[k] = PORT_W'($urandom);
      end else if (k > 0 && r < 4) begin
        pool_a[k] = $urandom;
        pool_p[k] = pool_p[k-1];
      end else begin
        pool_a[k] = (r == 4) ? '0 : (r == 5) ? '1 : $urandom;
        pool_p[k] = (r == 6) ? '0 : (r == 7) ? '1 : PORT_W'($urandom);
      end
    end
    burst_left = $urandom_range(24, 1);
    for (n = 0; n < count; n++) begin
      if (n == count / 2 && event_code == PH_LONG_HOLD) stall_reqs++;
      if (n == count / 2 && event_code == PH_DRAIN_PAUSE) drain_results();
      if (gaps && burst_left == 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(12, 1)) @(negedge clk_i);
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      // pick a key: pool, live table entry, or noise
      r = $urandom_range(99);
      k = $urandom_range(pool_n - 1);
      a = pool_a[k];
      p = pool_p[k];
      if (r >= 75 && r < 85 && sess_len > 0) begin
        s = $urandom_range(sess_len - 1);
        if (sess_used[s]) begin
          a = sess_addr[s];
          p = sess_port[s];
        end
      end else if (r >= 85) begin
        a = $urandom;
        p = PORT_W'($urandom);
      end
      // pick a mode
      r = $urandom_range(99);
      if (r < bias) m = MODE_CREATE;
      else begin
        r = $urandom_range(99);
        if (r < 35) m = MODE_LOOKUP;
        else if (r < 65) m = MODE_REMOVE;
        else if (r < 80) m = MODE_NEXT;
        else if (r < 87) m = MODE_REWIND;
        else if (r < 94) m = MODE_END;
        else m = $urandom_range(1) ? MODE_RSVD6 : MODE_RSVD7;
      end
      // pick a hint: right slot, any slot, length boundary, or none
      r = $urandom_range(99);
      if (r < 35) begin
        s = key_find(-1, a, p);
        h = (s >= 0) ? HINT_W'(s) : HINT_W'($urandom_range(63));
      end else if (r < 50) begin
        h = HINT_W'($urandom_range(63));
      end else if (r < 60) begin
        s = sess_len - int'($urandom_range(1));
        h = HINT_W'((s > 63) ? 63 : (s < 0) ? 0 : s);
      end else begin
        h = HINT_W'($urandom_range(127, 64));
      end
      row_typed = 1'b0;
      send_item(m, a, p, h);
    end
  endtask

  initial begin : stimulus
    int i;
    stim_row_t row;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    max_sessions_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_LOOKUP;
    peer_address_i = '0;
    peer_port_i = '0;
    slot_hint_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    stall_reqs = 0;
    bad_results = 0;
    sess_len = 0;
    walk_pos = 0;
    sess_limit = 0;
    for (i = 0; i < SLOTS; i++) begin
      sess_used[i] = 1'b0;
      sess_addr[i] = '0;
      sess_port[i] = '0;
    end

    // Directed rows under a limit of two sessions; keys A, B, C
    add_row(MODE_LOOKUP, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 0);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 0);
    add_row(MODE_CREATE, 32'h0, 16'h0, -1, 1, ST_CREATED, 0, 0, 0, 1);
    add_row(MODE_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 63, 1, ST_CREATED, 1, 0, 0, 2);
    add_row(MODE_CREATE, 32'h8000_0001, 16'h8001, -64, 1, ST_FULL, 0, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, ST_FOUND, 1, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 0, 1, ST_FOUND, 1, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, -2, 1, ST_FOUND, 1, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'h0, 16'hFFFF, 0, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'h0, 16'h0, 2, 1, ST_FOUND, 0, 0, 0, 2);
    add_row(MODE_REWIND, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 1, ST_FOUND, 0, 32'h0, 16'h0, 2);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 1, ST_FOUND, 1, 32'hFFFF_FFFF, 16'hFFFF, 2);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 0, ST_NONE, 0, 0, 0, 0);
    add_row(MODE_END, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_REMOVE, 32'h0, 16'h0, -1, 1, ST_REMOVED, 0, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'h0, 16'h0, 0, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_REMOVE, 32'h0, 16'h0, 0, 1, ST_NONE, 0, 0, 0, 2);
    add_row(MODE_CREATE, 32'h8000_0001, 16'h8001, -1, 0, ST_NONE, 0, 0, 0, 0);
    add_row(MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, ST_REMOVED, 1, 0, 0, 1);
    add_row(MODE_RSVD6, 32'h8000_0001, 16'h8001, -1, 1, ST_NONE, 0, 0, 0, 1);
    add_row(MODE_RSVD7, 32'h8000_0001, 16'h8001, 0, 1, ST_NONE, 0, 0, 0, 1);
    add_row(MODE_REMOVE, 32'h8000_0001, 16'h8001, 0, 1, ST_REMOVED, 0, 0, 0, 0);
    add_row(MODE_NEXT, 32'h0, 16'h0, -1, 1, ST_NONE, 0, 0, 0, 0);

    // Hold reset, then release at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_limit(2);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      row_typed = row.typed;
      row_want = row.want;
      send_item(row.mode, row.addr, row.port, row.hint);
    end
    row_typed = 1'b0;

    // Random phases: limit, items, create bias, pool size, sender gaps, event
    run_phase(0, 300, 55, 80, 1, PH_PLAIN);
    run_phase(64, 200, 40, 80, 0, PH_LONG_HOLD);
    run_phase(1, 150, 40, 6, 1, PH_PLAIN);
    run_phase(5, 200, 35, 12, 1, PH_DRAIN_PAUSE);
    run_phase(63, 200, 30, 70, 0, PH_PLAIN);
    run_phase(16, 200, 20, 30, 1, PH_PLAIN);
    run_phase(0, 150, 45, 40, 1, PH_PLAIN);

    drain_results();
    repeat (TAIL) @(negedge clk_i);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
design/stla_pkg.sv
design/stla_ram.sv
design/session_table_lookup_alloc.sv
dv/session_table_lookup_alloc_tb.sv
